@@ design/fel_pkg.sv @@
package fel_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int DELAY_W        = 14;
    localparam int GAIN_W         = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 14;
    localparam int LINE_DEPTH_DEF = 16384;
    localparam int OUT_DEPTH      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LPEN  = 2'd2;

    localparam logic [DELAY_W-1:0] DELAY_RST = 14'd0;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 8'd51;
    localparam logic               LPEN_RST  = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic    mark;
        sample_t right;
        sample_t left;
    } item_t;

    typedef struct packed {
        logic accept;
        logic bypass;
        logic rd_ok;
    } core_ctl_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic              lp_en;
    } core_cfg_t;

endpackage

@@ design/feedback_echo_with_lowpass.sv @@
// Channel   Dir  Ports                                  Carries
// s_        in   s_tvalid s_tready s_tdata s_tlast      stereo sample, block end mark
// m_        out  m_tvalid m_tready m_tdata m_tlast      stereo sample with echo, mark
// cfg_      in   cfg_wr_en cfg_index cfg_wdata          delay, feedback gain, lowpass on
//
// One transaction per cycle while s_tready is high; the input is registered into
// stage 1, then stage 2, then the output queue. The line memory is read at acceptance
// and written back in the following cycle, so an echo of one sample is served from a
// forwarding register instead of the memory. A fill flag and the write position mark
// which line entries hold data, and entries never written since reset read as zero.
// A four-deep output queue with an in-flight count lets input keep flowing while
// the output stalls; s_tready drops only when four transactions are outstanding.
module feedback_echo_with_lowpass #(
    parameter int LINE_DEPTH = fel_pkg::LINE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // left_in [15:0], right_in [31:16]
    input  logic                            s_tlast,   // block_end_in

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // left_out [15:0], right_out [31:16]
    output logic                            m_tlast,   // block_end_out

    input  logic                            cfg_wr_en,
    input  logic [fel_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fel_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int AW  = $clog2(LINE_DEPTH);
    localparam int CW  = $clog2(LINE_DEPTH + 1);
    localparam int DLW = (CW > fel_pkg::DELAY_W) ? CW : fel_pkg::DELAY_W;
    localparam int SW  = DLW + 1;
    localparam int IW  = $clog2(fel_pkg::OUT_DEPTH + 1);

    // configuration registers
    logic [fel_pkg::DELAY_W-1:0] delay_reg;
    logic [fel_pkg::GAIN_W-1:0]  gain_reg;
    logic                        lp_en_reg;

    // line bookkeeping
    logic [AW-1:0] wp_reg, wp_next;
    logic          filled_reg, filled_next;
    logic [IW-1:0] inflight_reg, inflight_next;

    logic [DLW-1:0] delay_ext;
    logic [DLW-1:0] d_clamp;
    logic [SW-1:0]  rd_diff;
    logic [SW-1:0]  rd_wrap;
    logic [AW-1:0]  rd_addr;

    logic               accept;
    logic               bypass;
    logic               m_accept;
    fel_pkg::core_ctl_t ctl;
    fel_pkg::core_cfg_t ccfg;
    fel_pkg::item_t     in_item;
    fel_pkg::item_t     out_item;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    fel_pkg::sample_t   ram_wdata;
    fel_pkg::sample_t   ram_rdata;
    logic               push;
    fel_pkg::item_t     push_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= fel_pkg::DELAY_RST;
            gain_reg  <= fel_pkg::GAIN_RST;
            lp_en_reg <= fel_pkg::LPEN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                fel_pkg::CFG_IDX_DELAY: begin
                    delay_reg <= cfg_wdata;
                end
                fel_pkg::CFG_IDX_GAIN: begin
                    gain_reg <= cfg_wdata[fel_pkg::GAIN_W-1:0];
                end
                fel_pkg::CFG_IDX_LPEN: begin
                    lp_en_reg <= cfg_wdata[0];
                end
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // accept while fewer transactions are outstanding than the queue can hold
    assign s_tready = (inflight_reg < IW'(fel_pkg::OUT_DEPTH));
    assign accept   = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;
    assign bypass   = (delay_reg == '0);

    // read address: write position minus the delay, clamped to the line depth
    always_comb begin
        delay_ext = DLW'(delay_reg);
        d_clamp   = (delay_ext > DLW'(LINE_DEPTH)) ? DLW'(LINE_DEPTH) : delay_ext;
        rd_diff   = SW'(wp_reg) - SW'(d_clamp);
        rd_wrap   = rd_diff[SW-1] ? rd_diff + SW'(LINE_DEPTH) : rd_diff;
        rd_addr   = rd_wrap[AW-1:0];
    end

    always_comb begin
        wp_next       = wp_reg;
        filled_next   = filled_reg;
        inflight_next = inflight_reg;
        // advance the write position on every non-bypass transaction
        if (accept && !bypass) begin
            if (wp_reg == AW'(LINE_DEPTH - 1)) begin
                wp_next     = '0;
                filled_next = 1'b1;
            end else begin
                wp_next = wp_reg + 1'b1;
            end
        end
        if (accept && !m_accept) begin
            inflight_next = inflight_reg + 1'b1;
        end else if (m_accept && !accept) begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            filled_reg   <= 1'b0;
            inflight_reg <= '0;
        end else begin
            wp_reg       <= wp_next;
            filled_reg   <= filled_next;
            inflight_reg <= inflight_next;
        end
    end

    always_comb begin
        in_item.left  = s_tdata[15:0];
        in_item.right = s_tdata[31:16];
        in_item.mark  = s_tlast;
        ctl.accept    = accept;
        ctl.bypass    = bypass;
        // entries not yet written since reset read as zero
        ctl.rd_ok     = filled_reg || (rd_addr < wp_reg);
        ccfg.gain     = gain_reg;
        ccfg.lp_en    = lp_en_reg;
    end

    fel_ram #(
        .WIDTH (fel_pkg::SAMPLE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    fel_core #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .cfg       (ccfg),
        .item      (in_item),
        .wp_addr   (wp_reg),
        .rd_addr   (rd_addr),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .push      (push),
        .push_item (push_item)
    );

    fel_out_fifo #(
        .DEPTH (fel_pkg::OUT_DEPTH)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_item    (out_item)
    );

    assign m_tdata = {out_item.right, out_item.left};
    assign m_tlast = out_item.mark;

    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= IW'(fel_pkg::OUT_DEPTH))
        else $error("outstanding transaction count above queue depth");

    a_valid_has_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (inflight_reg != '0))
        else $error("output valid with no transaction outstanding");

    a_bypass_holds_wp: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && bypass) |=> $stable(wp_reg))
        else $error("write position moved on a bypassed transaction");

endmodule

@@ design/fel_ram.sv @@
module fel_ram #(
    parameter int WIDTH = fel_pkg::SAMPLE_W,
    parameter int DEPTH = fel_pkg::LINE_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/fel_core.sv @@
module fel_core #(
    parameter int LINE_DEPTH = fel_pkg::LINE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fel_pkg::core_ctl_t            ctl,
    input  fel_pkg::core_cfg_t            cfg,
    input  fel_pkg::item_t                item,
    input  logic [$clog2(LINE_DEPTH)-1:0] wp_addr,
    input  logic [$clog2(LINE_DEPTH)-1:0] rd_addr,
    input  fel_pkg::sample_t              ram_rdata,
    output logic                          ram_we,
    output logic [$clog2(LINE_DEPTH)-1:0] ram_waddr,
    output fel_pkg::sample_t              ram_wdata,
    output logic                          push,
    output fel_pkg::item_t                push_item
);

    localparam int AW = $clog2(LINE_DEPTH);

    // stage 1: line read data arrives, echo value formed and written back
    logic             s1_valid_reg, s1_valid_next;
    fel_pkg::item_t   s1_item_reg;
    logic             s1_bypass_reg;
    logic             s1_rd_ok_reg;
    logic [AW-1:0]    s1_wp_reg;

    logic             fwd_valid_reg, fwd_valid_next;
    fel_pkg::sample_t fwd_data_reg;

    fel_pkg::sample_t older_reg, older_next;
    fel_pkg::sample_t newer_reg, newer_next;

    // stage 2: echo added to both channels
    logic             s2_valid_reg;
    fel_pkg::item_t   s2_item_reg;
    fel_pkg::sample_t s2_q_reg;

    fel_pkg::sample_t     delayed;
    logic                 silent;
    logic signed [16:0]   lr_sum;
    fel_pkg::sample_t     half;
    logic signed [24:0]   prod;
    logic signed [17:0]   mix;
    fel_pkg::sample_t     mix_sat;
    logic signed [18:0]   lp_sum;
    fel_pkg::sample_t     echo;
    fel_pkg::sample_t     wr_val;
    fel_pkg::sample_t     q_val;
    logic signed [16:0]   l_sum;
    logic signed [16:0]   r_sum;

    function automatic fel_pkg::sample_t sat17(input logic signed [16:0] v);
        fel_pkg::sample_t r;
        if (v[16] != v[15]) begin
            r = v[16] ? 16'sh8000 : 16'sh7fff;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    always_comb begin
        delayed = fwd_valid_reg ? fwd_data_reg : (s1_rd_ok_reg ? ram_rdata : '0);
        silent  = (delayed == '0) && (s1_item_reg.left == '0) && (s1_item_reg.right == '0);

        lr_sum  = {s1_item_reg.left[15], s1_item_reg.left}
                + {s1_item_reg.right[15], s1_item_reg.right};
        half    = lr_sum[16:1];
        prod    = $signed({1'b0, cfg.gain}) * delayed;
        mix     = {{2{half[15]}}, half} + {prod[24], prod[24:8]};
        if (mix[17] && !(&mix[16:15])) begin
            mix_sat = 16'sh8000;
        end else if (!mix[17] && (|mix[16:15])) begin
            mix_sat = 16'sh7fff;
        end else begin
            mix_sat = mix[15:0];
        end

        // (1,1,2)/4: the two previous unfiltered values once each, the current one twice
        lp_sum  = {{3{older_reg[15]}}, older_reg} + {{3{newer_reg[15]}}, newer_reg}
                + {{2{mix_sat[15]}}, mix_sat, 1'b0};
        echo    = cfg.lp_en ? lp_sum[17:2] : mix_sat;
        wr_val  = silent ? '0 : echo;
        q_val   = s1_bypass_reg ? '0 : {{2{wr_val[15]}}, wr_val[15:2]};
    end

    assign ram_we    = s1_valid_reg && !s1_bypass_reg;
    assign ram_waddr = s1_wp_reg;
    assign ram_wdata = wr_val;

    always_comb begin
        s1_valid_next  = ctl.accept;
        // the next item reads the entry that is being written right now
        fwd_valid_next = ctl.accept && ram_we && (rd_addr == s1_wp_reg);
        older_next     = older_reg;
        newer_next     = newer_reg;
        if (ram_we) begin
            if (silent) begin
                older_next = '0;
                newer_next = '0;
            end else if (cfg.lp_en) begin
                older_next = newer_reg;
                newer_next = mix_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            older_reg     <= '0;
            newer_reg     <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s1_valid_reg;
            fwd_valid_reg <= fwd_valid_next;
            older_reg     <= older_next;
            newer_reg     <= newer_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            s1_item_reg   <= item;
            s1_bypass_reg <= ctl.bypass;
            s1_rd_ok_reg  <= ctl.rd_ok;
            s1_wp_reg     <= wp_addr;
        end
        fwd_data_reg <= wr_val;
        if (s1_valid_reg) begin
            s2_item_reg <= s1_item_reg;
            s2_q_reg    <= q_val;
        end
    end

    always_comb begin
        l_sum          = {s2_item_reg.left[15], s2_item_reg.left} + {s2_q_reg[15], s2_q_reg};
        r_sum          = {s2_item_reg.right[15], s2_item_reg.right} + {s2_q_reg[15], s2_q_reg};
        push           = s2_valid_reg;
        push_item.left  = sat17(l_sum);
        push_item.right = sat17(r_sum);
        push_item.mark  = s2_item_reg.mark;
    end

    a_s2_follows_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg |-> $past(s1_valid_reg))
        else $error("stage 2 valid without a stage 1 item");

endmodule

@@ design/fel_out_fifo.sv @@
module fel_out_fifo #(
    parameter int DEPTH = fel_pkg::OUT_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fel_pkg::item_t push_item,
    output logic           m_tvalid,
    input  logic           m_tready,
    output fel_pkg::item_t m_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fel_pkg::item_t mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           pop;

    assign m_tvalid = (count_reg != '0);
    assign m_item   = mem[rd_ptr_reg];
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < CW'(DEPTH)))
        else $error("result pushed into a full output queue");

endmodule
